// ===== src/qau_pkg.sv =====
// Package for the quaternion arithmetic unit: widths, mode codes and the
// transaction and stage types. It depends on nothing else.
package qau_pkg;

  // Component format: signed fixed point, Q3.12 by default.
  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  // Configuration register.
  localparam int LIMIT_WIDTH = 15;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(1);
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_SMALL_NORM_LIMIT = 1'b0;

  // Internal widths, all derived from the component format.
  localparam int SUM_W    = 2 * COMP_WIDTH + 2;              // sum of four products
  localparam int WIDE_W   = 2 * COMP_WIDTH - FRAC_BITS + 4;  // rounded, unclipped result
  localparam int SUMSQ_W  = 2 * COMP_WIDTH + 1;              // exact sum of squares
  localparam int ROOT_W   = SUMSQ_W + 1;                     // root accumulator
  localparam int ROOT_STEPS = (SUMSQ_W + 1) / 2;             // one result bit per step
  localparam int LEN_W    = COMP_WIDTH + 1;                  // rounded length
  localparam int NORM2_W  = SUMSQ_W - FRAC_BITS + 1;         // squared norm and divisor
  localparam int NUM_W    = COMP_WIDTH + FRAC_BITS;          // dividend and quotient
  localparam int VAL_W    = NUM_W + 1;                       // signed value before clipping

  // Mode codes.
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DOT  = 3'd3;
  localparam logic [2:0] MODE_NEG  = 3'd4;
  localparam logic [2:0] MODE_INV  = 3'd5;
  localparam logic [2:0] MODE_NORM = 3'd6;
  localparam logic [2:0] MODE_LEN  = 3'd7;

  typedef struct packed {
    logic [2:0]                   mode;
    logic signed [COMP_WIDTH-1:0] a_w;
    logic signed [COMP_WIDTH-1:0] a_x;
    logic signed [COMP_WIDTH-1:0] a_y;
    logic signed [COMP_WIDTH-1:0] a_z;
    logic signed [COMP_WIDTH-1:0] b_w;
    logic signed [COMP_WIDTH-1:0] b_x;
    logic signed [COMP_WIDTH-1:0] b_y;
    logic signed [COMP_WIDTH-1:0] b_z;
  } in_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] res_w;
    logic signed [COMP_WIDTH-1:0] res_x;
    logic signed [COMP_WIDTH-1:0] res_y;
    logic signed [COMP_WIDTH-1:0] res_z;
    logic                         operands_equal;
    logic                         degenerate;
    logic                         saturated;
  } out_t;

  // What the front stages hand to the root and divider pipeline.
  typedef struct packed {
    logic [2:0]                  mode;
    logic                        eq;
    logic                        degen;
    logic [3:0]                  neg;   // sign of a divided lane's result
    logic [3:0][WIDE_W-1:0]      rw;    // direct result, or operand for division
    logic [NORM2_W-1:0]          n2;
  } base_t;

endpackage

// ===== src/qau_backend.sv =====
// Root and divider pipeline of the quaternion arithmetic unit, with the final
// clipping and the output register. Depends on qau_pkg.
module qau_backend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qau_pkg::base_t                in_base,
  input  logic [qau_pkg::SUMSQ_W-1:0]   in_sumsq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qau_pkg::out_t                 out_data
);

  localparam int W      = qau_pkg::COMP_WIDTH;
  localparam int F      = qau_pkg::FRAC_BITS;
  localparam int SQW    = qau_pkg::SUMSQ_W;
  localparam int RTW    = qau_pkg::ROOT_W;
  localparam int RSTEPS = qau_pkg::ROOT_STEPS;
  localparam int N2W    = qau_pkg::NORM2_W;
  localparam int NW     = qau_pkg::NUM_W;
  localparam int DSTEPS = qau_pkg::NUM_W;
  localparam int WW     = qau_pkg::WIDE_W;
  localparam int VW     = qau_pkg::VAL_W;
  localparam int LW     = qau_pkg::LEN_W;
  localparam logic signed [VW-1:0] VMAX = VW'((1 << (W - 1)) - 1);
  localparam logic signed [VW-1:0] VMIN = ~VMAX;

  typedef struct packed {
    qau_pkg::base_t  base;
    logic [SQW-1:0]  x;
    logic [RTW-1:0]  r;
  } root_st_t;

  typedef struct packed {
    qau_pkg::base_t        base;
    logic [N2W-1:0]        d;
    logic [3:0][NW-1:0]    num;
    logic [3:0][N2W-1:0]   rem;
  } div_st_t;

  root_st_t   root_r   [RSTEPS];
  logic       root_v_r [RSTEPS];
  logic       root_rdy [RSTEPS];
  div_st_t    prep_r, prep_nxt;
  logic       prep_v_r, prep_rdy;
  div_st_t    div_r    [DSTEPS];
  logic       div_v_r  [DSTEPS];
  logic       div_rdy  [DSTEPS];
  qau_pkg::out_t out_r, out_nxt;
  logic       out_v_r, out_rdy;

  assign in_ready = root_rdy[0];

  // Square root, one result bit per stage.
  genvar k;
  generate
    for (k = 0; k < RSTEPS; k++) begin : g_root
      localparam logic [RTW-1:0] BIT = RTW'(1) << (2 * (RSTEPS - 1 - k));
      root_st_t src, root_nxt;
      logic     srcv, nrdy;
      logic [RTW-1:0] trial;
      if (k == 0) begin : g_first
        assign src  = '{base: in_base, x: in_sumsq, r: '0};
        assign srcv = in_valid;
      end else begin : g_next
        assign src  = root_r[k-1];
        assign srcv = root_v_r[k-1];
      end
      if (k == RSTEPS - 1) begin : g_last
        assign nrdy = prep_rdy;
      end else begin : g_mid
        assign nrdy = root_rdy[k+1];
      end
      assign root_rdy[k] = !root_v_r[k] || nrdy;
      assign trial = src.r + BIT;

      always_comb begin
        root_nxt = src;
        if ({1'b0, src.x} >= trial) begin
          root_nxt.x = src.x - trial[SQW-1:0];
          root_nxt.r = (src.r >> 1) + BIT;
        end else begin
          root_nxt.r = src.r >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          root_v_r[k] <= 1'b0;
        end else if (root_rdy[k]) begin
          root_v_r[k] <= srcv;
        end
      end

      always_ff @(posedge clk) begin
        if (root_rdy[k] && srcv) begin
          root_r[k] <= root_nxt;
        end
      end
    end
  endgenerate

  // Rounds the root, picks the divisor and forms the rounded dividends.
  always_comb begin
    root_st_t         rs;
    logic [RTW-1:0]   lfull;
    logic [LW-1:0]    len;
    logic [N2W-1:0]   d;
    logic [WW-1:0]    v;
    logic [WW-1:0]    mag;
    rs    = root_r[RSTEPS-1];
    lfull = rs.r + RTW'({1'b0, rs.x} > rs.r);
    len   = lfull[LW-1:0];
    prep_nxt.base = rs.base;
    if (rs.base.mode == qau_pkg::MODE_LEN) begin
      prep_nxt.base.rw[0] = WW'(len);
    end
    d = (rs.base.mode == qau_pkg::MODE_INV) ? rs.base.n2 : N2W'(len);
    if (d == '0) begin
      d = N2W'(1);
    end
    prep_nxt.d = d;
    for (int i = 0; i < 4; i++) begin
      v   = rs.base.rw[i];
      mag = v[WW-1] ? -v : v;
      prep_nxt.num[i] = {mag[W-1:0], {F{1'b0}}} + NW'(d >> 1);
      prep_nxt.rem[i] = '0;
    end
  end

  assign prep_rdy = !prep_v_r || div_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (prep_rdy) begin
      prep_v_r <= root_v_r[RSTEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (prep_rdy && root_v_r[RSTEPS-1]) begin
      prep_r <= prep_nxt;
    end
  end

  // Restoring division, one quotient bit per stage in each of four lanes.
  generate
    for (k = 0; k < DSTEPS; k++) begin : g_div
      div_st_t src, div_nxt;
      logic    srcv, nrdy;
      if (k == 0) begin : g_first
        assign src  = prep_r;
        assign srcv = prep_v_r;
      end else begin : g_next
        assign src  = div_r[k-1];
        assign srcv = div_v_r[k-1];
      end
      if (k == DSTEPS - 1) begin : g_last
        assign nrdy = out_rdy;
      end else begin : g_mid
        assign nrdy = div_rdy[k+1];
      end
      assign div_rdy[k] = !div_v_r[k] || nrdy;

      always_comb begin
        logic [N2W:0] t;
        logic [N2W:0] diff;
        logic         ge;
        div_nxt = src;
        for (int i = 0; i < 4; i++) begin
          t    = {src.rem[i], src.num[i][NW-1]};
          ge   = t >= {1'b0, src.d};
          diff = t - {1'b0, src.d};
          div_nxt.rem[i] = ge ? diff[N2W-1:0] : t[N2W-1:0];
          div_nxt.num[i] = {src.num[i][NW-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          div_v_r[k] <= 1'b0;
        end else if (div_rdy[k]) begin
          div_v_r[k] <= srcv;
        end
      end

      always_ff @(posedge clk) begin
        if (div_rdy[k] && srcv) begin
          div_r[k] <= div_nxt;
        end
      end
    end
  endgenerate

  // Selects quotient or direct result per lane and clips to the component range.
  always_comb begin
    div_st_t                 ds;
    logic                    use_q;
    logic                    sat;
    logic signed [VW-1:0]    val;
    logic [3:0][W-1:0]       res;
    ds    = div_r[DSTEPS-1];
    use_q = (ds.base.mode == qau_pkg::MODE_INV || ds.base.mode == qau_pkg::MODE_NORM)
            && !ds.base.degen;
    sat   = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (use_q) begin
        val = ds.base.neg[i] ? -$signed({1'b0, ds.num[i]}) : $signed({1'b0, ds.num[i]});
      end else begin
        val = $signed({{(VW - WW){ds.base.rw[i][WW-1]}}, ds.base.rw[i]});
      end
      if (val > VMAX) begin
        val = VMAX;
        sat = 1'b1;
      end else if (val < VMIN) begin
        val = VMIN;
        sat = 1'b1;
      end
      res[i] = val[W-1:0];
    end
    out_nxt.res_w          = res[0];
    out_nxt.res_x          = res[1];
    out_nxt.res_y          = res[2];
    out_nxt.res_z          = res[3];
    out_nxt.operands_equal = ds.base.eq;
    out_nxt.degenerate     = ds.base.degen;
    out_nxt.saturated      = sat;
  end

  // Output register.
  assign out_rdy = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= div_v_r[DSTEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && div_v_r[DSTEPS-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // The degenerate flag only ever travels with inverse or normalize.
  a_degen_mode: assert property (@(posedge clk) disable iff (!rst_n)
    prep_v_r && prep_r.base.degen |->
      (prep_r.base.mode == qau_pkg::MODE_INV || prep_r.base.mode == qau_pkg::MODE_NORM))
    else $error("degenerate flag outside inverse or normalize");

  // A normalize that is not degenerate always has a non-zero length.
  a_norm_len: assert property (@(posedge clk) disable iff (!rst_n)
    root_v_r[RSTEPS-1] && root_r[RSTEPS-1].base.mode == qau_pkg::MODE_NORM &&
      !root_r[RSTEPS-1].base.degen |-> root_r[RSTEPS-1].r != '0)
    else $error("zero length reached the divider in normalize");

  // The divider remainders stay below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    div_v_r[DSTEPS-1] |->
      (div_r[DSTEPS-1].rem[0] < div_r[DSTEPS-1].d) && (div_r[DSTEPS-1].rem[1] < div_r[DSTEPS-1].d) &&
      (div_r[DSTEPS-1].rem[2] < div_r[DSTEPS-1].d) && (div_r[DSTEPS-1].rem[3] < div_r[DSTEPS-1].d))
    else $error("divider remainder out of range");

  // A result only appears when the last divider stage held a transaction.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(div_v_r[DSTEPS-1]))
    else $error("output valid without a source transaction");

endmodule

// ===== src/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit: top level with the configuration register, the
// multiply and sum stages, and the root and divider pipeline (qau_backend).
// Throughput: one transaction per cycle while the output is not stalled; the depth is set
// by the 17-step square root and the 28-step restoring divider. Stalls fill bubbles before
// stopping the input. Reset clears every valid bit and sets small_norm_limit to 1.
// Depends on qau_pkg.
module quaternion_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  qau_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output qau_pkg::out_t                     out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qau_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int W   = qau_pkg::COMP_WIDTH;
  localparam int F   = qau_pkg::FRAC_BITS;
  localparam int SW  = qau_pkg::SUM_W;
  localparam int WW  = qau_pkg::WIDE_W;
  localparam int SQW = qau_pkg::SUMSQ_W;
  localparam int N2W = qau_pkg::NORM2_W;
  localparam int LMW = qau_pkg::LIMIT_WIDTH;

  typedef struct packed {
    logic [2:0]             mode;
    logic                   eq;
    logic [3:0][W-1:0]      a;
    logic [3:0][W-1:0]      b;
    logic [15:0][2*W-1:0]   prod;
    logic [3:0][2*W-1:0]    sq;
  } s1_t;

  logic [LMW-1:0]       limit_r;
  logic                 reg_sel;
  s1_t                  s1_r, s1_nxt;
  logic                 s1_v_r, s1_rdy;
  qau_pkg::base_t       s2_base_r, s2_base_nxt;
  logic [SQW-1:0]       s2_sumsq_r, s2_sumsq_nxt;
  logic                 s2_v_r, s2_rdy;
  logic                 be_ready;

  // Configuration register.
  assign reg_sel = (paddr[qau_pkg::CFG_ADDR_W-1:2] == qau_pkg::REG_SMALL_NORM_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(limit_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= qau_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_r <= pwdata[LMW-1:0];
    end
  end

  function automatic logic signed [SW-1:0] sx(input logic [2*W-1:0] v);
    return $signed({{(SW - 2*W){v[2*W-1]}}, v});
  endfunction

  function automatic logic signed [WW-1:0] wx(input logic [W-1:0] v);
    return $signed({{(WW - W){v[W-1]}}, v});
  endfunction

  // Divide by 2^F, rounding half up.
  function automatic logic [WW-1:0] round_sum(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] q;
    t = s + $signed(SW'(1) << (F - 1));
    q = t >>> F;
    return q[WW-1:0];
  endfunction

  // Stage one: operand equality, all sixteen cross products and the squares.
  always_comb begin
    logic [3:0][W-1:0] av;
    logic [3:0][W-1:0] bv;
    av = {in_data.a_z, in_data.a_y, in_data.a_x, in_data.a_w};
    bv = {in_data.b_z, in_data.b_y, in_data.b_x, in_data.b_w};
    s1_nxt.mode = in_data.mode;
    s1_nxt.eq   = (av == bv);
    s1_nxt.a    = av;
    s1_nxt.b    = bv;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s1_nxt.prod[i*4+j] = $signed(av[i]) * $signed(bv[j]);
      end
      s1_nxt.sq[i] = $signed(av[i]) * $signed(av[i]);
    end
  end

  assign s2_rdy   = !s2_v_r || be_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage two: sums, rounding, squared norm and the per-mode direct result.
  always_comb begin
    logic signed [SW-1:0] p [16];
    logic signed [SW-1:0] hm [4];
    logic signed [SW-1:0] dot;
    logic signed [WW-1:0] wa [4];
    logic signed [WW-1:0] wb [4];
    logic [SQW-1:0]       ss;
    logic [N2W-1:0]       n2;
    logic                 dg;
    for (int k = 0; k < 16; k++) begin
      p[k] = sx(s1_r.prod[k]);
    end
    hm[0] = p[0] - p[5] - p[10] - p[15];
    hm[1] = p[1] + p[4] + p[11] - p[14];
    hm[2] = p[2] - p[7] + p[8] + p[13];
    hm[3] = p[3] + p[6] - p[9] + p[12];
    dot   = p[0] + p[5] + p[10] + p[15];
    ss = SQW'(s1_r.sq[0]) + SQW'(s1_r.sq[1]) + SQW'(s1_r.sq[2]) + SQW'(s1_r.sq[3]);
    n2 = N2W'(ss >> F) + N2W'(ss[F-1]);
    dg = (s1_r.mode == qau_pkg::MODE_INV || s1_r.mode == qau_pkg::MODE_NORM) &&
         (n2 <= N2W'(limit_r));
    for (int i = 0; i < 4; i++) begin
      wa[i] = wx(s1_r.a[i]);
      wb[i] = wx(s1_r.b[i]);
      s2_base_nxt.neg[i] = s1_r.a[i][W-1] ^ ((s1_r.mode == qau_pkg::MODE_INV) && (i != 0));
    end
    s2_base_nxt.mode  = s1_r.mode;
    s2_base_nxt.eq    = s1_r.eq;
    s2_base_nxt.degen = dg;
    s2_base_nxt.n2    = n2;
    s2_base_nxt.rw    = '0;
    unique case (s1_r.mode)
      qau_pkg::MODE_ADD: begin
        for (int i = 0; i < 4; i++) s2_base_nxt.rw[i] = wa[i] + wb[i];
      end
      qau_pkg::MODE_SUB: begin
        for (int i = 0; i < 4; i++) s2_base_nxt.rw[i] = wa[i] - wb[i];
      end
      qau_pkg::MODE_MUL: begin
        for (int i = 0; i < 4; i++) s2_base_nxt.rw[i] = round_sum(hm[i]);
      end
      qau_pkg::MODE_DOT: begin
        s2_base_nxt.rw[0] = round_sum(dot);
      end
      qau_pkg::MODE_NEG: begin
        for (int i = 0; i < 4; i++) s2_base_nxt.rw[i] = -wa[i];
      end
      qau_pkg::MODE_INV: begin
        // The degenerate case returns the plain conjugate.
        s2_base_nxt.rw[0] = wa[0];
        for (int i = 1; i < 4; i++) s2_base_nxt.rw[i] = dg ? -wa[i] : wa[i];
      end
      qau_pkg::MODE_NORM: begin
        if (!dg) begin
          for (int i = 0; i < 4; i++) s2_base_nxt.rw[i] = wa[i];
        end
      end
      qau_pkg::MODE_LEN: begin
        s2_base_nxt.rw = '0;
      end
      default: begin
        s2_base_nxt.rw = '0;
      end
    endcase
    s2_sumsq_nxt = ss;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_base_r  <= s2_base_nxt;
      s2_sumsq_r <= s2_sumsq_nxt;
    end
  end

  // Square root, division, clipping and the output register.
  qau_backend u_backend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_ready  (be_ready),
    .in_base   (s2_base_r),
    .in_sumsq  (s2_sumsq_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
